// ----- hw/rtl/r5ftc_pkg.sv -----
// r5ftc_pkg: shared constants and types for the rgb555 fade-to-color unit
// no dependencies

package r5ftc_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 10;
    localparam int CH_W       = 8;
    localparam int PIX_D_W    = 16;
    localparam int PPF_W      = 10;
    localparam int FRAC_W     = 12;
    localparam int FACTOR_W   = 13;
    localparam int PROD_W     = 21;
    localparam int SUM_W      = 22;
    localparam int DIV_STEPS  = 12;
    localparam int DIV_CNT_W  = 4;

    localparam logic [FACTOR_W-1:0] FACTOR_ONE = 13'h1000;

    localparam logic [CFG_ADDR_W-1:0] CFG_TARGET_RED   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TARGET_GREEN = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TARGET_BLUE  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_FADE_STEPS   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_PIXELS       = 3'd4;

    typedef struct packed {
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [CH_W-1:0]  steps;
        logic [PPF_W-1:0] pixels;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic comp_load;
        logic mul_load;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic need_div;
    } status_t;

endpackage

// ----- hw/rtl/r5ftc_cfg_regs.sv -----
// r5ftc_cfg_regs: configuration register file with write decode
// depends on r5ftc_pkg

module r5ftc_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [r5ftc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [r5ftc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output r5ftc_pkg::cfg_t                 cfg
);

    logic [r5ftc_pkg::CH_W-1:0]  red_reg,   red_next;
    logic [r5ftc_pkg::CH_W-1:0]  green_reg, green_next;
    logic [r5ftc_pkg::CH_W-1:0]  blue_reg,  blue_next;
    logic [r5ftc_pkg::CH_W-1:0]  steps_reg, steps_next;
    logic [r5ftc_pkg::PPF_W-1:0] ppf_reg,   ppf_next;

    always_comb begin
        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        steps_next = steps_reg;
        ppf_next   = ppf_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                r5ftc_pkg::CFG_TARGET_RED:   red_next   = cfg_wdata[r5ftc_pkg::CH_W-1:0];
                r5ftc_pkg::CFG_TARGET_GREEN: green_next = cfg_wdata[r5ftc_pkg::CH_W-1:0];
                r5ftc_pkg::CFG_TARGET_BLUE:  blue_next  = cfg_wdata[r5ftc_pkg::CH_W-1:0];
                r5ftc_pkg::CFG_FADE_STEPS:   steps_next = cfg_wdata[r5ftc_pkg::CH_W-1:0];
                r5ftc_pkg::CFG_PIXELS:       ppf_next   = cfg_wdata[r5ftc_pkg::PPF_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_reg   <= '0;
            green_reg <= '0;
            blue_reg  <= '0;
            steps_reg <= 8'd1;
            ppf_reg   <= 10'd512;
        end else begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            steps_reg <= steps_next;
            ppf_reg   <= ppf_next;
        end
    end

    // zero steps behaves as one
    always_comb begin
        cfg.red    = red_reg;
        cfg.green  = green_reg;
        cfg.blue   = blue_reg;
        cfg.steps  = (steps_reg == '0) ? 8'd1 : steps_reg;
        cfg.pixels = ppf_reg;
    end

endmodule

// ----- hw/rtl/r5ftc_ctrl.sv -----
// r5ftc_ctrl: sequencer for accept, factor division, complement, multiply and pack
// depends on r5ftc_pkg

module r5ftc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  r5ftc_pkg::status_t  status,
    output r5ftc_pkg::cmd_t     cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_COMP = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_PACK = 5'b10000
    } state_t;

    localparam logic [r5ftc_pkg::DIV_CNT_W-1:0] DIV_LAST =
        r5ftc_pkg::DIV_CNT_W'(r5ftc_pkg::DIV_STEPS - 1);

    state_t                             state_reg, state_next;
    logic [r5ftc_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic                               m_valid_reg, m_valid_next;
    logic                               out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = status.need_div ? ST_DIV : ST_MUL;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_COMP;
                end
            end
            ST_COMP: begin
                cmd.comp_load = 1'b1;
                state_next    = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_load = 1'b1;
                state_next   = ST_PACK;
            end
            ST_PACK: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        priority if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- hw/rtl/r5ftc_datapath.sv -----
// r5ftc_datapath: frame counters, bit-serial factor divider, blend and output register
// depends on r5ftc_pkg

module r5ftc_datapath #(
    parameter int MAX_PIXELS = 512
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  r5ftc_pkg::cfg_t                 cfg,
    input  r5ftc_pkg::cmd_t                 cmd,
    output r5ftc_pkg::status_t              status,
    input  logic [r5ftc_pkg::PIX_D_W-1:0]   pixel_in,
    output logic [r5ftc_pkg::PIX_D_W-1:0]   pixel_out,
    output logic                            frame_last,
    output logic                            fade_last
);

    localparam int PIX_W = $clog2(MAX_PIXELS + 1);
    localparam int CMP_W = (PIX_W > r5ftc_pkg::PPF_W) ? PIX_W : r5ftc_pkg::PPF_W;
    localparam logic [CMP_W-1:0] MAX_PIX = CMP_W'(MAX_PIXELS);
    localparam int CH_W = r5ftc_pkg::CH_W;
    localparam int FW   = r5ftc_pkg::FACTOR_W;

    logic [CH_W-1:0]               step_index_reg, step_index_next;
    logic [PIX_W-1:0]              pixel_index_reg, pixel_index_next;
    logic [r5ftc_pkg::PIX_D_W-1:0] pixel_reg;
    logic                          final_reg, last_reg;
    logic [CH_W-1:0]               rem_reg;
    logic [FW-1:0]                 factor_reg, factor_next;
    logic [FW-1:0]                 comp_reg, comp_next;
    logic [r5ftc_pkg::PROD_W-1:0]  rs_prod_reg, gs_prod_reg, bs_prod_reg;
    logic [r5ftc_pkg::PROD_W-1:0]  rt_prod_reg, gt_prod_reg, bt_prod_reg;
    logic [r5ftc_pkg::PIX_D_W-1:0] pixel_out_reg;
    logic                          frame_last_reg, fade_last_reg;

    logic [CMP_W-1:0]  npix, npix_m1, pix_ext;
    logic [CH_W-1:0]   steps_m1, s_sat;
    logic [CH_W:0]     s_p1, steps_ext, rem2, rem2_sub, s_p1_sub;
    logic              is_final, is_last, div_int, div_ge;
    logic [CH_W-1:0]   rem0;
    logic [CH_W-1:0]   rs, gs, bs;
    logic [r5ftc_pkg::SUM_W-1:0] rsum, gsum, bsum;
    logic [r5ftc_pkg::PIX_D_W-1:0] target_px, blend_px, result_px;

    // frame length, zero as one, saturated to the pixel capacity
    always_comb begin
        npix = CMP_W'(cfg.pixels);
        if (npix == '0) begin
            npix = CMP_W'(1);
        end
        if (npix > MAX_PIX) begin
            npix = MAX_PIX;
        end
        npix_m1 = npix - CMP_W'(1);
        pix_ext = CMP_W'(pixel_index_reg);
    end

    assign steps_m1  = cfg.steps - 1'b1;
    assign is_final  = step_index_reg >= steps_m1;
    assign is_last   = pix_ext >= npix_m1;
    assign s_sat     = (step_index_reg > steps_m1) ? steps_m1 : step_index_reg;
    assign s_p1      = {1'b0, s_sat} + 1'b1;
    assign steps_ext = {1'b0, cfg.steps};
    assign s_p1_sub  = s_p1 - steps_ext;
    assign div_int   = s_p1 >= steps_ext;
    assign rem0      = div_int ? s_p1_sub[CH_W-1:0] : s_p1[CH_W-1:0];
    assign rem2      = {rem_reg, 1'b0};
    assign rem2_sub  = rem2 - steps_ext;
    assign div_ge    = rem2 >= steps_ext;

    assign status.need_div = (pixel_index_reg == '0);

    always_comb begin
        step_index_next  = step_index_reg;
        pixel_index_next = pixel_index_reg;
        if (cmd.accept) begin
            if (is_last) begin
                pixel_index_next = '0;
                step_index_next  = is_final ? '0 : step_index_reg + 1'b1;
            end else begin
                pixel_index_next = pixel_index_reg + 1'b1;
            end
        end
    end

    always_comb begin
        factor_next = factor_reg;
        comp_next   = comp_reg;
        priority if (cmd.accept && status.need_div) begin
            factor_next = FW'(div_int);
        end else if (cmd.div_step) begin
            factor_next = {factor_reg[FW-2:0], div_ge};
        end else if (cmd.comp_load) begin
            comp_next = r5ftc_pkg::FACTOR_ONE - factor_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_index_reg  <= '0;
            pixel_index_reg <= '0;
            factor_reg      <= r5ftc_pkg::FACTOR_ONE;
            comp_reg        <= '0;
        end else begin
            step_index_reg  <= step_index_next;
            pixel_index_reg <= pixel_index_next;
            factor_reg      <= factor_next;
            comp_reg        <= comp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            pixel_reg <= pixel_in;
            final_reg <= is_final;
            last_reg  <= is_last;
            rem_reg   <= rem0;
        end else if (cmd.div_step) begin
            rem_reg <= div_ge ? rem2_sub[CH_W-1:0] : rem2[CH_W-1:0];
        end
    end

    assign rs = {pixel_reg[4:0], 3'b000};
    assign gs = {pixel_reg[9:5], 3'b000};
    assign bs = {pixel_reg[14:10], 3'b000};

    always_ff @(posedge aclk) begin
        if (cmd.mul_load) begin
            rs_prod_reg <= r5ftc_pkg::PROD_W'(rs * comp_reg);
            gs_prod_reg <= r5ftc_pkg::PROD_W'(gs * comp_reg);
            bs_prod_reg <= r5ftc_pkg::PROD_W'(bs * comp_reg);
            rt_prod_reg <= r5ftc_pkg::PROD_W'(cfg.red * factor_reg);
            gt_prod_reg <= r5ftc_pkg::PROD_W'(cfg.green * factor_reg);
            bt_prod_reg <= r5ftc_pkg::PROD_W'(cfg.blue * factor_reg);
        end
    end

    assign rsum = r5ftc_pkg::SUM_W'(rs_prod_reg) + r5ftc_pkg::SUM_W'(rt_prod_reg);
    assign gsum = r5ftc_pkg::SUM_W'(gs_prod_reg) + r5ftc_pkg::SUM_W'(gt_prod_reg);
    assign bsum = r5ftc_pkg::SUM_W'(bs_prod_reg) + r5ftc_pkg::SUM_W'(bt_prod_reg);

    assign target_px = {1'b1, cfg.blue[7:3], cfg.green[7:3], cfg.red[7:3]};
    assign blend_px  = {pixel_reg[15], bsum[19:15], gsum[19:15], rsum[19:15]};

    always_comb begin
        priority if (pixel_reg == '0) begin
            result_px = '0;
        end else if (final_reg) begin
            result_px = target_px;
        end else begin
            result_px = blend_px;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            pixel_out_reg  <= result_px;
            frame_last_reg <= last_reg;
            fade_last_reg  <= last_reg && final_reg;
        end
    end

    assign pixel_out  = pixel_out_reg;
    assign frame_last = frame_last_reg;
    assign fade_last  = fade_last_reg;

endmodule

// ----- hw/rtl/rgb555_fade_to_color_unit.sv -----
// rgb555_fade_to_color_unit: top level, config registers, sequencer and datapath
// depends on r5ftc_pkg, r5ftc_cfg_regs, r5ftc_ctrl, r5ftc_datapath
//
//   channel   direction  handshake          payload
//   s_        in         s_valid / s_ready  s_pixel_in[15:0]
//   m_        out        m_valid / m_ready  m_pixel_out[15:0], m_frame_last, m_fade_last
//   cfg_      in         cfg_we             cfg_addr[2:0], cfg_wdata[9:0]
//
// the first word of a frame occupies the unit through accept, the one-bit-per-cycle factor
// divider, the complement, multiply and pack; other words through accept, multiply and pack;
// each result is loaded into the output register at pack; a stalled result keeps the next
// word in the pack stage and drops s_ready
// a new word is taken while the previous result waits in the output register
// reset is synchronous active low on aresetn and clears counters and handshake state

module rgb555_fade_to_color_unit #(
    parameter int MAX_PIXELS = 512
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [r5ftc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [r5ftc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [r5ftc_pkg::PIX_D_W-1:0]    s_pixel_in,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [r5ftc_pkg::PIX_D_W-1:0]    m_pixel_out,
    output logic                             m_frame_last,
    output logic                             m_fade_last
);

    r5ftc_pkg::cfg_t    cfg;
    r5ftc_pkg::cmd_t    cmd;
    r5ftc_pkg::status_t status;

    r5ftc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    r5ftc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    r5ftc_datapath #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .cmd        (cmd),
        .status     (status),
        .pixel_in   (s_pixel_in),
        .pixel_out  (m_pixel_out),
        .frame_last (m_frame_last),
        .fade_last  (m_fade_last)
    );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// testbench for rgb555_fade_to_color_unit: random and directed pixel streams,
// checked word by word against a fade predictor held in a small scoreboard class
// depends on r5ftc_pkg and rgb555_fade_to_color_unit

module testbench;

    localparam int CFG_ADDR_W = r5ftc_pkg::CFG_ADDR_W;
    localparam int CFG_DATA_W = r5ftc_pkg::CFG_DATA_W;
    localparam int CH_W       = r5ftc_pkg::CH_W;
    localparam int PIX_D_W    = r5ftc_pkg::PIX_D_W;
    localparam int PPF_W      = r5ftc_pkg::PPF_W;
    localparam int FRAC_W     = r5ftc_pkg::FRAC_W;
    localparam int FACTOR_W   = r5ftc_pkg::FACTOR_W;
    localparam logic [FACTOR_W-1:0] FACTOR_ONE = r5ftc_pkg::FACTOR_ONE;

    localparam int          MAX_PIXELS    = 512;
    localparam int          CYCLE_LIMIT   = 600000;
    localparam int          SETTLE_CYCLES = 24;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          WORD_TARGET   = 1450;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = r5ftc_pkg::CFG_PIXELS + 3'd1;

    typedef struct packed {
        logic [PIX_D_W-1:0] pixel;
        logic               frame_end;
        logic               fade_end;
    } faded_word_t;

    class fade_checker;
        logic [CH_W-1:0]     tgt_red, tgt_green, tgt_blue, fade_steps;
        logic [PPF_W-1:0]    frame_pixels;
        logic [CH_W-1:0]     step_idx;
        logic [PPF_W-1:0]    pixel_idx;
        logic [FACTOR_W-1:0] factor, complement;
        faded_word_t         expected_words[$];
        int                  errors, frames_seen, fades_seen;

        function new();
            tgt_red = '0;
            tgt_green = '0;
            tgt_blue = '0;
            fade_steps = 8'd1;
            frame_pixels = 10'd512;
            step_idx = '0;
            pixel_idx = '0;
            factor = FACTOR_ONE;
            complement = '0;
            errors = 0;
            frames_seen = 0;
            fades_seen = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                r5ftc_pkg::CFG_TARGET_RED: begin
                    tgt_red = val[CH_W-1:0];
                end
                r5ftc_pkg::CFG_TARGET_GREEN: begin
                    tgt_green = val[CH_W-1:0];
                end
                r5ftc_pkg::CFG_TARGET_BLUE: begin
                    tgt_blue = val[CH_W-1:0];
                end
                r5ftc_pkg::CFG_FADE_STEPS: begin
                    fade_steps = val[CH_W-1:0];
                end
                r5ftc_pkg::CFG_PIXELS: begin
                    frame_pixels = val[PPF_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function faded_word_t fade_pixel(logic [PIX_D_W-1:0] px);
            faded_word_t w;
            int unsigned steps, npix, s, rsum, gsum, bsum;
            logic        final_frame;
            steps = (fade_steps == 0) ? 1 : fade_steps;
            npix = (frame_pixels == 0) ? 1 : frame_pixels;
            if (npix > MAX_PIXELS) npix = MAX_PIXELS;
            if (pixel_idx == 0) begin
                s = step_idx;
                if (s > steps - 1) s = steps - 1;
                factor = FACTOR_W'(((s + 1) << FRAC_W) / steps);
                complement = FACTOR_ONE - factor;
            end
            final_frame = (step_idx >= steps - 1);
            w.frame_end = (pixel_idx >= npix - 1);
            w.fade_end = w.frame_end && final_frame;
            if (px == 0) begin
                w.pixel = '0;
            end else if (final_frame) begin
                w.pixel = {1'b1, tgt_blue[7:3], tgt_green[7:3], tgt_red[7:3]};
            end else begin
                rsum = {px[4:0], 3'b000} * complement + tgt_red * factor;
                gsum = {px[9:5], 3'b000} * complement + tgt_green * factor;
                bsum = {px[14:10], 3'b000} * complement + tgt_blue * factor;
                w.pixel = {px[15], bsum[19:15], gsum[19:15], rsum[19:15]};
            end
            if (w.frame_end) begin
                pixel_idx = '0;
                step_idx = final_frame ? '0 : step_idx + 8'd1;
            end else begin
                pixel_idx = pixel_idx + 10'd1;
            end
            return w;
        endfunction

        function void take_pixel(logic [PIX_D_W-1:0] px);
            expected_words.push_back(fade_pixel(px));
        endfunction

        function void match_word(logic [PIX_D_W-1:0] px, logic fl, logic fdl);
            faded_word_t w;
            if (expected_words.size() == 0) begin
                errors++;
                $display("%0t: unexpected word pixel %h frame_last %b fade_last %b",
                         $time, px, fl, fdl);
                return;
            end
            w = expected_words.pop_front();
            frames_seen += fl;
            fades_seen += fdl;
            if (w.pixel !== px || w.frame_end !== fl || w.fade_end !== fdl) begin
                errors++;
                $display({"%0t: mismatch expected pixel %h frame_last %b fade_last %b,",
                          " actual pixel %h frame_last %b fade_last %b"},
                         $time, w.pixel, w.frame_end, w.fade_end, px, fl, fdl);
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [PIX_D_W-1:0]    s_pixel_in = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [PIX_D_W-1:0]    m_pixel_out;
    logic                  m_frame_last;
    logic                  m_fade_last;

    fade_checker book = new();
    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;
    bit          hold_req = 1'b0;
    int          words_sent = 0;
    int          settings_used = 0;
    int          cycles = 0;

    rgb555_fade_to_color_unit #(
        .MAX_PIXELS(MAX_PIXELS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_pixel_in(s_pixel_in),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_pixel_out(m_pixel_out),
        .m_frame_last(m_frame_last),
        .m_fade_last(m_fade_last)
    );

    initial begin
        forever begin
            #10 aclk = ~aclk;
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("%0t: timeout with %0d words outstanding", $time, book.pending());
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    // result side: check accepted words, then decide next ready
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                book.match_word(m_pixel_out, m_frame_last, m_fade_last);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    function automatic logic [PIX_D_W-1:0] random_pixel();
        case ($urandom_range(9))
            0: return '0;
            1: return 16'h8000;
            2: return 16'(1) << $urandom_range(15);
            default: return PIX_D_W'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        book.set_reg(idx, val);
    endtask

    task automatic end_writes();
        cfg_we <= 1'b0;
        @(posedge aclk);
        settings_used++;
    endtask

    task automatic send_word(input logic [PIX_D_W-1:0] px);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel_in <= px;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        book.take_pixel(px);
        words_sent++;
    endtask

    task automatic send_burst(input int n);
        repeat (n) send_word(random_pixel());
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (book.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_pace(input int mode);
        case (mode % 4)
            0: begin
                sender_idle_pct = 0;
                receiver_stall_pct = 0;
            end
            1: begin
                sender_idle_pct = 55;
                receiver_stall_pct = 0;
            end
            2: begin
                sender_idle_pct = 0;
                receiver_stall_pct = 55;
            end
            default: begin
                sender_idle_pct = 30;
                receiver_stall_pct = 30;
            end
        endcase
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_channel();
        case ($urandom_range(3))
            0: return '0;
            1: return 10'h0FF;
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_steps();
        case ($urandom_range(7))
            0: return '0;
            1: return 10'h0FF;
            default: return CFG_DATA_W'($urandom_range(6, 1))
                            | (CFG_DATA_W'($urandom_range(3)) << 8);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_pixels();
        case ($urandom_range(11))
            0: return '0;
            1: return 10'd512;
            default: return CFG_DATA_W'($urandom_range(8, 1));
        endcase
    endfunction

    localparam logic [PIX_D_W-1:0] EDGE_PIXELS [16] = '{
        16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h001F, 16'h03E0, 16'h7C00, 16'h0001,
        16'h8001, 16'h5555, 16'hAAAA, 16'h0421, 16'h7BDE, 16'h801F, 16'hFC00, 16'h0400
    };

    initial begin
        int phase;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: single final frame, black target
        for (int i = 0; i < 8; i++) send_word(EDGE_PIXELS[i]);
        settle();
        write_reg(r5ftc_pkg::CFG_TARGET_RED, 10'h3FF);
        write_reg(r5ftc_pkg::CFG_TARGET_GREEN, 10'h000);
        write_reg(r5ftc_pkg::CFG_TARGET_BLUE, 10'h180);
        write_reg(r5ftc_pkg::CFG_FADE_STEPS, 10'd3);
        write_reg(r5ftc_pkg::CFG_PIXELS, 10'd4);
        end_writes();
        for (int i = 0; i < 16; i++) send_word(EDGE_PIXELS[i]);
        settle();

        // longest fade, one pixel frames given as zero length
        set_pace(1);
        write_reg(r5ftc_pkg::CFG_FADE_STEPS, 10'h3FF);
        write_reg(r5ftc_pkg::CFG_PIXELS, 10'd0);
        write_reg(CFG_UNUSED, 10'd7);
        end_writes();
        send_burst(260);
        settle();

        // zero steps, oversized frame saturating to the maximum
        set_pace(3);
        write_reg(r5ftc_pkg::CFG_FADE_STEPS, 10'h100);
        write_reg(r5ftc_pkg::CFG_PIXELS, 10'h3FF);
        write_reg(r5ftc_pkg::CFG_TARGET_GREEN, 10'h0FF);
        end_writes();
        send_burst(520);
        settle();

        // shrink steps and frame length in the middle of a fade
        set_pace(0);
        write_reg(r5ftc_pkg::CFG_FADE_STEPS, 10'd6);
        write_reg(r5ftc_pkg::CFG_PIXELS, 10'd5);
        end_writes();
        send_burst(17);
        settle();
        write_reg(r5ftc_pkg::CFG_FADE_STEPS, 10'd2);
        write_reg(r5ftc_pkg::CFG_PIXELS, 10'd2);
        end_writes();
        send_burst(9);
        settle();

        phase = 0;
        while (words_sent < WORD_TARGET) begin
            set_pace(phase);
            if ($urandom_range(9) < 6) write_reg(r5ftc_pkg::CFG_TARGET_RED, pick_channel());
            if ($urandom_range(9) < 6) write_reg(r5ftc_pkg::CFG_TARGET_GREEN, pick_channel());
            if ($urandom_range(9) < 6) write_reg(r5ftc_pkg::CFG_TARGET_BLUE, pick_channel());
            if ($urandom_range(9) < 6) write_reg(r5ftc_pkg::CFG_FADE_STEPS, pick_steps());
            if ($urandom_range(9) < 6) write_reg(r5ftc_pkg::CFG_PIXELS, pick_pixels());
            if ($urandom_range(9) < 3)
                write_reg(CFG_UNUSED + CFG_ADDR_W'($urandom_range(2)), CFG_DATA_W'($urandom));
            end_writes();
            if (phase == 4) hold_req = 1'b1;
            send_burst($urandom_range(80, 30));
            settle();
            phase++;
        end

        $display("testbench: %0d words sent under %0d register settings", words_sent,
                 settings_used);
        $display("testbench: %0d frame ends and %0d completed fades checked, %0d errors",
                 book.frames_seen, book.fades_seen, book.errors);
        if (book.errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
